// File: sv/ioc_pkg.sv
// ----------------------------------------------------------------------------
// ioc_pkg: shared types, constants and microcode for the orientation filter
// Holds the control word format, the microprogram ROM, the arctangent table
// and the fixed datapath widths used by the sequencer and both datapaths.
// ----------------------------------------------------------------------------
package ioc_pkg;

  // Datapath widths fixed by the sample and result formats.
  localparam int OPW      = 17;  // sign-extended (and possibly negated) sensor word
  localparam int TAB_FRAC = 24;  // fraction bits of the CORDIC angle accumulator
  localparam int XW       = 44;  // CORDIC x/y registers: 17 + 24 bits plus growth
  localparam int ZW       = 34;  // CORDIC angle accumulator, degrees with 24 fraction bits
  localparam int ANG_W    = 32;  // stored and reported angles
  localparam int ALPHA_W  = 17;
  localparam int GAIN_W   = 24;
  localparam int PC_W     = 5;

  // Configuration register indices.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 4'd1;

  // Ninety degrees in accumulator format, used by the quadrant pre-rotation.
  localparam logic signed [ZW-1:0] Z90 = 34'sd1509949440;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_ROLL  = 2'd0;
  localparam axis_t AX_PITCH = 2'd1;
  localparam axis_t AX_YAW   = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_CLOAD,
    OP_CITER,
    OP_CSTORE,
    OP_GAIN,
    OP_INNER,
    OP_ALPHA,
    OP_BETA,
    OP_FSTORE,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    H_NONE,
    H_INPUT,
    H_OUTPUT
  } hold_t;

  typedef enum logic [1:0] {
    B_NEXT,
    B_LOOP,
    B_JUMP
  } br_t;

  // One microcode word.
  typedef struct packed {
    op_t             op;
    axis_t           axis;
    hold_t           hold;
    br_t             br;
    logic [PC_W-1:0] target;
  } uword_t;

  // Control handed from the sequencer to the datapaths.
  typedef struct packed {
    op_t   op;
    axis_t axis;
  } ctl_t;

  function automatic uword_t uw(input op_t op, input axis_t ax, input hold_t h,
                                input br_t b, input logic [PC_W-1:0] t);
    uword_t w;
    w.op     = op;
    w.axis   = ax;
    w.hold   = h;
    w.br     = b;
    w.target = t;
    return w;
  endfunction

  // Microprogram: wait, three CORDIC runs, three filter updates, emit.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = uw(OP_WAIT,   AX_ROLL,  H_INPUT,  B_NEXT, 5'd0);
      5'd1:    w = uw(OP_CLOAD,  AX_ROLL,  H_NONE,   B_NEXT, 5'd0);
      5'd2:    w = uw(OP_CITER,  AX_ROLL,  H_NONE,   B_LOOP, 5'd2);
      5'd3:    w = uw(OP_CSTORE, AX_ROLL,  H_NONE,   B_NEXT, 5'd0);
      5'd4:    w = uw(OP_CLOAD,  AX_PITCH, H_NONE,   B_NEXT, 5'd0);
      5'd5:    w = uw(OP_CITER,  AX_PITCH, H_NONE,   B_LOOP, 5'd5);
      5'd6:    w = uw(OP_CSTORE, AX_PITCH, H_NONE,   B_NEXT, 5'd0);
      5'd7:    w = uw(OP_CLOAD,  AX_YAW,   H_NONE,   B_NEXT, 5'd0);
      5'd8:    w = uw(OP_CITER,  AX_YAW,   H_NONE,   B_LOOP, 5'd8);
      5'd9:    w = uw(OP_CSTORE, AX_YAW,   H_NONE,   B_NEXT, 5'd0);
      5'd10:   w = uw(OP_GAIN,   AX_ROLL,  H_NONE,   B_NEXT, 5'd0);
      5'd11:   w = uw(OP_INNER,  AX_ROLL,  H_NONE,   B_NEXT, 5'd0);
      5'd12:   w = uw(OP_ALPHA,  AX_ROLL,  H_NONE,   B_NEXT, 5'd0);
      5'd13:   w = uw(OP_BETA,   AX_ROLL,  H_NONE,   B_NEXT, 5'd0);
      5'd14:   w = uw(OP_FSTORE, AX_ROLL,  H_NONE,   B_NEXT, 5'd0);
      5'd15:   w = uw(OP_GAIN,   AX_PITCH, H_NONE,   B_NEXT, 5'd0);
      5'd16:   w = uw(OP_INNER,  AX_PITCH, H_NONE,   B_NEXT, 5'd0);
      5'd17:   w = uw(OP_ALPHA,  AX_PITCH, H_NONE,   B_NEXT, 5'd0);
      5'd18:   w = uw(OP_BETA,   AX_PITCH, H_NONE,   B_NEXT, 5'd0);
      5'd19:   w = uw(OP_FSTORE, AX_PITCH, H_NONE,   B_NEXT, 5'd0);
      5'd20:   w = uw(OP_GAIN,   AX_YAW,   H_NONE,   B_NEXT, 5'd0);
      5'd21:   w = uw(OP_INNER,  AX_YAW,   H_NONE,   B_NEXT, 5'd0);
      5'd22:   w = uw(OP_ALPHA,  AX_YAW,   H_NONE,   B_NEXT, 5'd0);
      5'd23:   w = uw(OP_BETA,   AX_YAW,   H_NONE,   B_NEXT, 5'd0);
      5'd24:   w = uw(OP_FSTORE, AX_YAW,   H_NONE,   B_NEXT, 5'd0);
      5'd25:   w = uw(OP_EMIT,   AX_ROLL,  H_OUTPUT, B_JUMP, 5'd0);
      default: w = uw(OP_NOP,    AX_ROLL,  H_NONE,   B_JUMP, 5'd0);
    endcase
    return w;
  endfunction

  // atan(2^-i) in degrees with 24 fraction bits.
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/ioc_useq.sv
// ----------------------------------------------------------------------------
// ioc_useq: microcode sequencer
// Step counter over the microprogram ROM with hold conditions on the input
// and output handshakes and a counted loop for the CORDIC iterations.
// ----------------------------------------------------------------------------
module ioc_useq #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  output ioc_pkg::ctl_t       ctl_o,
  output logic [(CORDIC_STEPS > 1 ? $clog2(CORDIC_STEPS) : 1)-1:0] iter_o
);

  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int PCW    = ioc_pkg::PC_W;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  logic [PCW-1:0]    pc_r, pc_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  ioc_pkg::uword_t   word;
  logic              stall;

  // Step counter and loop counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      iter_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      iter_r <= iter_nxt;
    end
  end

  // Fetch the current word and work out the next step.
  always_comb begin
    word  = ioc_pkg::ucode(pc_r);
    stall = ((word.hold == ioc_pkg::H_INPUT) && !in_valid) ||
            ((word.hold == ioc_pkg::H_OUTPUT) && !out_free);
    pc_nxt   = pc_r;
    iter_nxt = iter_r;
    if (!stall) begin
      case (word.br)
        ioc_pkg::B_NEXT: begin
          pc_nxt = pc_r + PCW'(1);
        end
        ioc_pkg::B_JUMP: begin
          pc_nxt = word.target;
        end
        ioc_pkg::B_LOOP: begin
          if (iter_r == ITER_LAST) begin
            pc_nxt   = pc_r + PCW'(1);
            iter_nxt = '0;
          end else begin
            pc_nxt   = word.target;
            iter_nxt = iter_r + ITER_W'(1);
          end
        end
        default: begin
          pc_nxt = '0;
        end
      endcase
    end
  end

  assign ctl_o.op   = word.op;
  assign ctl_o.axis = word.axis;
  assign iter_o     = iter_r;

endmodule

// File: sv/ioc_cordic.sv
// ----------------------------------------------------------------------------
// ioc_cordic: shared CORDIC vectoring unit
// Loads a vector with quadrant pre-rotation, runs one iteration per step and
// stores the rounded accelerometer angle of the selected axis.
// ----------------------------------------------------------------------------
module ioc_cordic #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  ioc_pkg::ctl_t                     ctl,
  input  logic [(CORDIC_STEPS > 1 ? $clog2(CORDIC_STEPS) : 1)-1:0] iter,
  input  logic signed [ioc_pkg::OPW-1:0]    acc_x,
  input  logic signed [ioc_pkg::OPW-1:0]    acc_y,
  input  logic signed [ioc_pkg::OPW-1:0]    acc_z,
  output logic [2:0][ioc_pkg::ANG_W-1:0]    ang_o
);

  localparam int XW   = ioc_pkg::XW;
  localparam int ZW   = ioc_pkg::ZW;
  localparam int OPW  = ioc_pkg::OPW;
  localparam int TF   = ioc_pkg::TAB_FRAC;
  localparam int AW   = ioc_pkg::ANG_W;
  localparam int XPAD = XW - OPW - TF;
  localparam int SH   = TF - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] RND = ZW'(64'd1 << (SH - 1));

  logic signed [XW-1:0]  x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic                  zero_r;
  logic [2:0][AW-1:0]    ang_r;

  logic signed [OPW-1:0] xs_sel, ys_sel;
  logic signed [XW-1:0]  ld_x, ld_y, x_ld, y_ld, xsh, ysh, x_it, y_it;
  logic signed [ZW-1:0]  z_ld, z_it, tab, z_rnd;
  logic                  zero_ld;
  logic signed [AW-1:0]  res;

  always_comb begin
    // Operand pair of the axis in hand: atan2(y, x).
    case (ctl.axis)
      ioc_pkg::AX_ROLL: begin
        ys_sel = acc_y;
        xs_sel = acc_z;
      end
      ioc_pkg::AX_PITCH: begin
        ys_sel = acc_x;
        xs_sel = acc_z;
      end
      default: begin
        ys_sel = acc_x;
        xs_sel = acc_y;
      end
    endcase
    ld_x    = $signed({{XPAD{xs_sel[OPW-1]}}, xs_sel, {TF{1'b0}}});
    ld_y    = $signed({{XPAD{ys_sel[OPW-1]}}, ys_sel, {TF{1'b0}}});
    zero_ld = (xs_sel == '0) && (ys_sel == '0);

    // Turn a left half-plane vector by a quarter turn.
    if (ld_x[XW-1]) begin
      if (!ld_y[XW-1]) begin
        x_ld = ld_y;
        y_ld = -ld_x;
        z_ld = ioc_pkg::Z90;
      end else begin
        x_ld = -ld_y;
        y_ld = ld_x;
        z_ld = -ioc_pkg::Z90;
      end
    end else begin
      x_ld = ld_x;
      y_ld = ld_y;
      z_ld = '0;
    end

    // One vectoring iteration.
    xsh = x_r >>> iter;
    ysh = y_r >>> iter;
    tab = $signed({{(ZW - 30){1'b0}}, ioc_pkg::atan_deg(5'(iter))});
    if (y_r[XW-1]) begin
      x_it = x_r - ysh;
      y_it = y_r + xsh;
      z_it = z_r - tab;
    end else begin
      x_it = x_r + ysh;
      y_it = y_r - xsh;
      z_it = z_r + tab;
    end

    // Round half up to the output fraction; zero vector gives zero.
    z_rnd = (z_r + RND) >>> SH;
    res   = $signed(z_rnd[AW-1:0]);
    if (zero_r) begin
      res = '0;
    end else if (ctl.axis == ioc_pkg::AX_PITCH) begin
      res = -res;
    end
  end

  // Vector, angle and result registers.
  always_ff @(posedge clk) begin
    case (ctl.op)
      ioc_pkg::OP_CLOAD: begin
        x_r    <= x_ld;
        y_r    <= y_ld;
        z_r    <= z_ld;
        zero_r <= zero_ld;
      end
      ioc_pkg::OP_CITER: begin
        x_r <= x_it;
        y_r <= y_it;
        z_r <= z_it;
      end
      ioc_pkg::OP_CSTORE: begin
        case (ctl.axis)
          ioc_pkg::AX_ROLL:  ang_r[0] <= res;
          ioc_pkg::AX_PITCH: ang_r[1] <= res;
          default:           ang_r[2] <= res;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign ang_o = ang_r;

endmodule

// File: sv/ioc_filter.sv
// ----------------------------------------------------------------------------
// ioc_filter: complementary filter datapath
// One shared multiplier forms the gyro increment and both weighted terms;
// the mix is rounded, saturated and written back to the angle store.
// ----------------------------------------------------------------------------
module ioc_filter #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  ioc_pkg::ctl_t                     ctl,
  input  logic [ioc_pkg::ALPHA_W-1:0]       alpha,
  input  logic [ioc_pkg::GAIN_W-1:0]        gain,
  input  logic signed [ioc_pkg::OPW-1:0]    gyr_x,
  input  logic signed [ioc_pkg::OPW-1:0]    gyr_y,
  input  logic signed [ioc_pkg::OPW-1:0]    gyr_z,
  input  logic [2:0][ioc_pkg::ANG_W-1:0]    ang_i,
  output logic [2:0][ioc_pkg::ANG_W-1:0]    store_o,
  output logic                              clip_o
);

  localparam int AW  = ioc_pkg::ANG_W;
  localparam int OPW = ioc_pkg::OPW;
  localparam int IW  = AW + 2;   // previous angle plus increment
  localparam int MBW = ioc_pkg::GAIN_W + 1;
  localparam int PW  = 52;       // largest product is alpha times inner sum
  localparam int SW  = PW + 1;
  localparam int GS  = 32 - ANGLE_FRAC_BITS;
  localparam logic signed [PW-1:0] GRND = PW'(64'd1 << (GS - 1));
  localparam logic signed [17:0]   ONE  = 18'sd65536;
  localparam logic signed [SW-1:0] HALF = 53'sd32768;

  logic [2:0][AW-1:0]       store_r;
  logic                     clip_r;
  logic signed [PW-1:0]     p_r, acc_r;
  logic signed [IW-1:0]     inner_r;

  logic signed [17:0]       alpha_c, beta;
  logic signed [OPW-1:0]    gyr_k;
  logic signed [AW-1:0]     store_k, ang_k;
  logic signed [IW-1:0]     ma;
  logic signed [MBW-1:0]    mb;
  logic signed [IW+MBW-1:0] prod;
  logic signed [PW-1:0]     inc;
  logic signed [IW-1:0]     inner_nxt;
  logic signed [SW-1:0]     mix, mix_sh;
  logic                     ovf;
  logic signed [AW-1:0]     sat;

  always_comb begin
    // Weights, with alpha clamped to one.
    alpha_c = (alpha > 17'd65536) ? ONE : $signed({1'b0, alpha});
    beta    = ONE - alpha_c;

    // Operands of the axis in hand.
    case (ctl.axis)
      ioc_pkg::AX_ROLL: begin
        gyr_k   = gyr_x;
        store_k = $signed(store_r[0]);
        ang_k   = $signed(ang_i[0]);
      end
      ioc_pkg::AX_PITCH: begin
        gyr_k   = gyr_y;
        store_k = $signed(store_r[1]);
        ang_k   = $signed(ang_i[1]);
      end
      default: begin
        gyr_k   = gyr_z;
        store_k = $signed(store_r[2]);
        ang_k   = $signed(ang_i[2]);
      end
    endcase

    // Shared multiplier operand selection.
    case (ctl.op)
      ioc_pkg::OP_GAIN: begin
        ma = $signed({{(IW - OPW){gyr_k[OPW-1]}}, gyr_k});
        mb = $signed({1'b0, gain});
      end
      ioc_pkg::OP_ALPHA: begin
        ma = inner_r;
        mb = $signed({{(MBW - 18){alpha_c[17]}}, alpha_c});
      end
      default: begin
        ma = $signed({{(IW - AW){ang_k[AW-1]}}, ang_k});
        mb = $signed({{(MBW - 18){beta[17]}}, beta});
      end
    endcase
    prod = ma * mb;

    // Gyro increment rounded half up, added to the previous angle.
    inc       = (p_r + GRND) >>> GS;
    inner_nxt = $signed({{(IW - AW){store_k[AW-1]}}, store_k}) + $signed(inc[IW-1:0]);

    // Weighted sum, rounded, then saturated to 32 bits.
    mix    = $signed({acc_r[PW-1], acc_r}) + $signed({p_r[PW-1], p_r}) + HALF;
    mix_sh = mix >>> 16;
    ovf    = !((&mix_sh[SW-1:AW-1]) || !(|mix_sh[SW-1:AW-1]));
    if (ovf) begin
      sat = mix_sh[SW-1] ? $signed({1'b1, {(AW - 1){1'b0}}})
                         : $signed({1'b0, {(AW - 1){1'b1}}});
    end else begin
      sat = $signed(mix_sh[AW-1:0]);
    end
  end

  // Working registers of the filter step.
  always_ff @(posedge clk) begin
    case (ctl.op)
      ioc_pkg::OP_GAIN:  p_r <= prod[PW-1:0];
      ioc_pkg::OP_INNER: inner_r <= inner_nxt;
      ioc_pkg::OP_ALPHA: p_r <= prod[PW-1:0];
      ioc_pkg::OP_BETA: begin
        acc_r <= p_r;
        p_r   <= prod[PW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Angle store and saturation flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      clip_r  <= 1'b0;
    end else if (start) begin
      clip_r <= 1'b0;
    end else if (ctl.op == ioc_pkg::OP_FSTORE) begin
      clip_r <= clip_r | ovf;
      case (ctl.axis)
        ioc_pkg::AX_ROLL:  store_r[0] <= sat;
        ioc_pkg::AX_PITCH: store_r[1] <= sat;
        default:           store_r[2] <= sat;
      endcase
    end
  end

  assign store_o = store_r;
  assign clip_o  = clip_r;

endmodule

// File: sv/imu_complementary_orientation.sv
// ----------------------------------------------------------------------------
// imu_complementary_orientation: complementary filter attitude estimator
// Takes a new item only on the wait step, once the previous one is emitted.
// Three atan2 runs on one CORDIC unit at one iteration a cycle, then five steps
// per axis on one shared multiplier. Reset clears the stored angles and the
// handshakes and restores both registers.
// ----------------------------------------------------------------------------
module imu_complementary_orientation #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Sample channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                in_accel_x_raw,
  input  logic signed [15:0]                in_accel_y_raw,
  input  logic signed [15:0]                in_accel_z_raw,
  input  logic signed [15:0]                in_gyro_x_raw,
  input  logic signed [15:0]                in_gyro_y_raw,
  input  logic signed [15:0]                in_gyro_z_raw,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_roll_angle,
  output logic signed [31:0]                out_pitch_angle,
  output logic signed [31:0]                out_yaw_angle,
  output logic                              out_clipped,
  // Configuration channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ioc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ioc_pkg::GAIN_W-1:0]        cfg_data
);

  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int OPW    = ioc_pkg::OPW;
  localparam int AW     = ioc_pkg::ANG_W;

  ioc_pkg::ctl_t                ctl;
  logic [ITER_W-1:0]            iter;
  logic                         accept, out_free, out_load;
  logic [ioc_pkg::ALPHA_W-1:0]  alpha_r;
  logic [ioc_pkg::GAIN_W-1:0]   gain_r;
  logic signed [OPW-1:0]        acc_x_r, acc_y_r, acc_z_r;
  logic signed [OPW-1:0]        gyr_x_r, gyr_y_r, gyr_z_r;
  logic [2:0][AW-1:0]           ang;
  logic [2:0][AW-1:0]           store;
  logic                         clip;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [AW-1:0]         out_roll_r, out_pitch_r, out_yaw_r;
  logic                         out_clip_r;

  // Handshake decode.
  assign in_ready  = (ctl.op == ioc_pkg::OP_WAIT);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (ctl.op == ioc_pkg::OP_EMIT) && out_free;
  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indices are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 17'd64225;
      gain_r  <= 24'd2618861;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ioc_pkg::REG_ALPHA: alpha_r <= cfg_data[ioc_pkg::ALPHA_W-1:0];
        ioc_pkg::REG_GAIN:  gain_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sample registers, with the axis sign conventions applied on entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_x_r <= $signed({in_accel_x_raw[15], in_accel_x_raw});
      acc_y_r <= $signed({in_accel_y_raw[15], in_accel_y_raw});
      acc_z_r <= -$signed({in_accel_z_raw[15], in_accel_z_raw});
      gyr_x_r <= -$signed({in_gyro_x_raw[15], in_gyro_x_raw});
      gyr_y_r <= -$signed({in_gyro_y_raw[15], in_gyro_y_raw});
      gyr_z_r <= $signed({in_gyro_z_raw[15], in_gyro_z_raw});
    end
  end

  ioc_useq #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctl_o    (ctl),
    .iter_o   (iter)
  );

  ioc_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .ctl   (ctl),
    .iter  (iter),
    .acc_x (acc_x_r),
    .acc_y (acc_y_r),
    .acc_z (acc_z_r),
    .ang_o (ang)
  );

  ioc_filter #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .ctl     (ctl),
    .alpha   (alpha_r),
    .gain    (gain_r),
    .gyr_x   (gyr_x_r),
    .gyr_y   (gyr_y_r),
    .gyr_z   (gyr_z_r),
    .ang_i   (ang),
    .store_o (store),
    .clip_o  (clip)
  );

  // Output register: holds a finished item until it is taken.
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_roll_r  <= $signed(store[0]);
      out_pitch_r <= $signed(store[1]);
      out_yaw_r   <= $signed(store[2]);
      out_clip_r  <= clip;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_yaw_angle   = out_yaw_r;
  assign out_clipped     = out_clip_r;

  // An accepted item always moves the sequencer off the wait step.
  a_accept_leaves_wait: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("sequencer stayed on the wait step after taking an item");

  // A result appears only from the emit step.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.op == ioc_pkg::OP_EMIT))
    else $error("result raised outside the emit step");

  // The iteration counter is idle outside the CORDIC loop.
  a_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op != ioc_pkg::OP_CITER) |-> (iter == '0))
    else $error("iteration counter not cleared outside the CORDIC loop");

  // A clipped result carries at least one angle at a range limit.
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clip_r) |->
      (out_roll_r == 32'sh7FFFFFFF || out_roll_r == -32'sh80000000 ||
       out_pitch_r == 32'sh7FFFFFFF || out_pitch_r == -32'sh80000000 ||
       out_yaw_r == 32'sh7FFFFFFF || out_yaw_r == -32'sh80000000))
    else $error("clipped flag set with no saturated angle");

endmodule
